>>> rtl/core/ooktc_pkg.sv
// ----------------------------------------------------------------------------
// ooktc_pkg
// Shared types and constants for the OOK pulse train capture unit.
// ----------------------------------------------------------------------------
package ooktc_pkg;

  localparam int PAIR_DEPTH_DEF    = 1024;
  localparam int DURATION_BITS_DEF = 20;

  localparam int CMD_W     = 2;
  localparam int TIME_W    = 32;
  localparam int TIMEOUT_W = 20;
  localparam int IDX_W     = 10;
  localparam int COUNT_W   = 11;
  localparam int DUR_OUT_W = 20;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd10000;

  typedef enum logic [CMD_W-1:0] {
    CMD_EDGE    = 2'd0,
    CMD_READ    = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_t;

  // status of one item, after its update
  typedef struct packed {
    logic               train_ready;
    logic [COUNT_W-1:0] pair_count;
    logic               entry_valid;
    logic               space_keep;
  } status_t;

  typedef struct packed {
    logic mark_we;
    logic space_we;
  } wr_strobe_t;

endpackage

>>> rtl/core/ooktc_ctrl.sv
// ----------------------------------------------------------------------------
// ooktc_ctrl
// Edge timing, train bookkeeping and store access generation.
// ----------------------------------------------------------------------------
module ooktc_ctrl import ooktc_pkg::*; #(
  parameter int PAIR_DEPTH    = PAIR_DEPTH_DEF,
  parameter int DURATION_BITS = DURATION_BITS_DEF,
  localparam int OFF_W  = $clog2(PAIR_DEPTH),
  localparam int ADDR_W = OFF_W + 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [TIMEOUT_W-1:0]     cfg_wr_data,
  input  logic                     accept,
  input  logic [CMD_W-1:0]         cmd,
  input  logic [TIME_W-1:0]        edge_time_us,
  input  logic                     line_high,
  input  logic [IDX_W-1:0]         entry_index,
  output wr_strobe_t               wr_strobe,
  output logic [ADDR_W-1:0]        wr_addr,
  output logic [DURATION_BITS-1:0] wr_mark,
  output logic [DURATION_BITS-1:0] wr_space,
  output logic [ADDR_W-1:0]        rd_addr,
  output status_t                  status
);

  localparam int CNT_W = $clog2(PAIR_DEPTH + 1);
  localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam logic [TIME_W-1:0] DUR_MAX = (TIME_W'(1) << DURATION_BITS) - TIME_W'(1);

  logic [TIMEOUT_W-1:0] timeout;
  logic [TIME_W-1:0]    last_edge_time, last_edge_time_next;
  logic                 in_mark, in_mark_next;
  logic                 active_buffer, active_buffer_next;
  logic                 train_pending, train_pending_next;
  logic [CNT_W-1:0]     act_count, act_count_next;
  logic                 act_ready, act_ready_next;
  logic [CNT_W-1:0]     rd_count, rd_count_next;
  logic                 rd_ready, rd_ready_next;

  cmd_t                     cmd_e;
  logic [TIME_W-1:0]        dur;
  logic                     dur_long;
  logic [DURATION_BITS-1:0] dur_clip;
  logic                     ready_now;
  logic [CNT_W-1:0]         count_now;
  logic [CMP_W-1:0]         idx_cmp;
  logic [CMP_W-1:0]         cnt_cmp;

  assign cmd_e    = cmd_t'(cmd);
  assign dur      = edge_time_us - last_edge_time;
  assign dur_long = dur >= TIME_W'(timeout);
  assign dur_clip = (dur > DUR_MAX) ? DUR_MAX[DURATION_BITS-1:0] : dur[DURATION_BITS-1:0];

  always_comb begin
    last_edge_time_next = last_edge_time;
    in_mark_next        = in_mark;
    active_buffer_next  = active_buffer;
    train_pending_next  = train_pending;
    act_count_next      = act_count;
    act_ready_next      = act_ready;
    rd_count_next       = rd_count;
    rd_ready_next       = rd_ready;
    wr_strobe           = '0;
    wr_addr             = {active_buffer, OFF_W'(act_count)};
    wr_mark             = dur_clip;
    wr_space            = '0;
    if (accept) begin
      unique case (cmd_e)
        CMD_EDGE: begin
          last_edge_time_next = edge_time_us;
          if (line_high) begin
            in_mark_next = 1'b1;
            if (dur_long) begin
              if (act_count > CNT_W'(1) && !act_ready) begin
                // close train: active side moves to read side
                rd_count_next      = act_count;
                rd_ready_next      = 1'b1;
                train_pending_next = 1'b1;
                active_buffer_next = ~active_buffer;
                act_count_next     = '0;
                act_ready_next     = 1'b0;
              end else begin
                act_count_next = '0;
              end
            end else if (act_count != '0) begin
              wr_strobe.space_we = 1'b1;
              wr_addr  = {active_buffer, OFF_W'(act_count - CNT_W'(1))};
              wr_space = dur_clip;
            end
          end else if (in_mark) begin
            in_mark_next = 1'b0;
            if (dur_long) begin
              act_count_next = '0;
            end else if (act_count < CNT_W'(PAIR_DEPTH)) begin
              wr_strobe.mark_we  = 1'b1;
              wr_strobe.space_we = 1'b1;
              act_count_next     = act_count + CNT_W'(1);
            end
          end
        end
        CMD_RELEASE: begin
          if (train_pending && rd_ready) begin
            rd_ready_next      = 1'b0;
            train_pending_next = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign ready_now = train_pending_next && rd_ready_next;
  assign count_now = ready_now ? rd_count_next : '0;
  assign idx_cmp   = CMP_W'(entry_index);
  assign cnt_cmp   = CMP_W'(count_now);
  assign rd_addr   = {~active_buffer_next, OFF_W'(entry_index)};

  always_comb begin
    status.train_ready = ready_now;
    status.pair_count  = COUNT_W'(count_now);
    status.entry_valid = (cmd_e == CMD_READ) && ready_now && (idx_cmp < cnt_cmp);
    status.space_keep  = (idx_cmp + CMP_W'(1)) < cnt_cmp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout        <= TIMEOUT_RESET;
      last_edge_time <= '0;
      in_mark        <= 1'b0;
      active_buffer  <= 1'b0;
      train_pending  <= 1'b0;
      act_count      <= '0;
      act_ready      <= 1'b0;
      rd_count       <= '0;
      rd_ready       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        timeout <= cfg_wr_data;
      end
      last_edge_time <= last_edge_time_next;
      in_mark        <= in_mark_next;
      active_buffer  <= active_buffer_next;
      train_pending  <= train_pending_next;
      act_count      <= act_count_next;
      act_ready      <= act_ready_next;
      rd_count       <= rd_count_next;
      rd_ready       <= rd_ready_next;
    end
  end

endmodule

>>> rtl/core/ooktc_store.sv
// ----------------------------------------------------------------------------
// ooktc_store
// Mark and space pair memories, both banks, one write and one read port.
// ----------------------------------------------------------------------------
module ooktc_store import ooktc_pkg::*; #(
  parameter int PAIR_DEPTH    = PAIR_DEPTH_DEF,
  parameter int DURATION_BITS = DURATION_BITS_DEF,
  localparam int OFF_W  = $clog2(PAIR_DEPTH),
  localparam int ADDR_W = OFF_W + 1
) (
  input  logic                     clk,
  input  wr_strobe_t               wr_strobe,
  input  logic [ADDR_W-1:0]        wr_addr,
  input  logic [DURATION_BITS-1:0] wr_mark,
  input  logic [DURATION_BITS-1:0] wr_space,
  input  logic                     rd_en,
  input  logic [ADDR_W-1:0]        rd_addr,
  output logic [DURATION_BITS-1:0] rd_mark,
  output logic [DURATION_BITS-1:0] rd_space
);

  localparam int DEPTH = 2 ** ADDR_W;

  logic [DURATION_BITS-1:0] mark_mem  [DEPTH];
  logic [DURATION_BITS-1:0] space_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_strobe.mark_we) begin
      mark_mem[wr_addr] <= wr_mark;
    end
    if (rd_en) begin
      rd_mark <= mark_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_strobe.space_we) begin
      space_mem[wr_addr] <= wr_space;
    end
    if (rd_en) begin
      rd_space <= space_mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/ooktc_out.sv
// ----------------------------------------------------------------------------
// ooktc_out
// Read-data alignment stage and output register.
// ----------------------------------------------------------------------------
module ooktc_out import ooktc_pkg::*; #(
  parameter int DURATION_BITS = DURATION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  status_t                  status,
  input  logic [DURATION_BITS-1:0] rd_mark,
  input  logic [DURATION_BITS-1:0] rd_space,
  output logic                     in_ready,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     train_ready,
  output logic [COUNT_W-1:0]       ready_pair_count,
  output logic                     entry_valid,
  output logic [DUR_OUT_W-1:0]     entry_mark_us,
  output logic [DUR_OUT_W-1:0]     entry_space_us
);

  logic    s1_valid;
  status_t s1_status;
  logic    s1_adv;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status <= status;
    end
    if (s1_adv) begin
      train_ready      <= s1_status.train_ready;
      ready_pair_count <= s1_status.pair_count;
      entry_valid      <= s1_status.entry_valid;
      entry_mark_us    <= s1_status.entry_valid ? DUR_OUT_W'(rd_mark) : '0;
      entry_space_us   <= (s1_status.entry_valid && s1_status.space_keep) ?
                          DUR_OUT_W'(rd_space) : '0;
    end
  end

endmodule

>>> rtl/core/ook_pulse_train_capture_unit.sv
// ----------------------------------------------------------------------------
// ook_pulse_train_capture_unit
// Mark/space pulse width capture into two ping-pong pair buffers.
//
//   channel  signals                                         direction
//   in       in_valid, in_ready, cmd, edge_time_us,          sink
//            line_high, entry_index
//   out      out_valid, out_ready, train_ready,              source
//            ready_pair_count, entry_valid, entry_mark_us,
//            entry_space_us
//   cfg      cfg_wr_en, cfg_wr_data (train timeout)          sink
//
// One item per clock unless the output stalls. A result passes the read
// stage and then the output register. The rate follows from the single write
// and single read port of the pair memories: each item does at most one of
// each. Reset clears counts and flags at once; pair memories keep no reset
// and only entries already written ever reach the outputs.
// Output stall: one item waits in the read stage, one in the output register.
// ----------------------------------------------------------------------------
module ook_pulse_train_capture_unit import ooktc_pkg::*; #(
  parameter int PAIR_DEPTH    = PAIR_DEPTH_DEF,
  parameter int DURATION_BITS = DURATION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [TIMEOUT_W-1:0] cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CMD_W-1:0]     cmd,
  input  logic [TIME_W-1:0]    edge_time_us,
  input  logic                 line_high,
  input  logic [IDX_W-1:0]     entry_index,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 train_ready,
  output logic [COUNT_W-1:0]   ready_pair_count,
  output logic                 entry_valid,
  output logic [DUR_OUT_W-1:0] entry_mark_us,
  output logic [DUR_OUT_W-1:0] entry_space_us
);

  localparam int ADDR_W = $clog2(PAIR_DEPTH) + 1;

  logic                     accept;
  wr_strobe_t               wr_strobe;
  logic [ADDR_W-1:0]        wr_addr;
  logic [DURATION_BITS-1:0] wr_mark;
  logic [DURATION_BITS-1:0] wr_space;
  logic [ADDR_W-1:0]        rd_addr;
  logic [DURATION_BITS-1:0] rd_mark;
  logic [DURATION_BITS-1:0] rd_space;
  status_t                  status;

  assign accept = in_valid && in_ready;

  ooktc_ctrl #(
    .PAIR_DEPTH    (PAIR_DEPTH),
    .DURATION_BITS (DURATION_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .accept       (accept),
    .cmd          (cmd),
    .edge_time_us (edge_time_us),
    .line_high    (line_high),
    .entry_index  (entry_index),
    .wr_strobe    (wr_strobe),
    .wr_addr      (wr_addr),
    .wr_mark      (wr_mark),
    .wr_space     (wr_space),
    .rd_addr      (rd_addr),
    .status       (status)
  );

  ooktc_store #(
    .PAIR_DEPTH    (PAIR_DEPTH),
    .DURATION_BITS (DURATION_BITS)
  ) u_store (
    .clk       (clk),
    .wr_strobe (wr_strobe),
    .wr_addr   (wr_addr),
    .wr_mark   (wr_mark),
    .wr_space  (wr_space),
    .rd_en     (accept),
    .rd_addr   (rd_addr),
    .rd_mark   (rd_mark),
    .rd_space  (rd_space)
  );

  ooktc_out #(
    .DURATION_BITS (DURATION_BITS)
  ) u_out (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .status           (status),
    .rd_mark          (rd_mark),
    .rd_space         (rd_space),
    .in_ready         (in_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .train_ready      (train_ready),
    .ready_pair_count (ready_pair_count),
    .entry_valid      (entry_valid),
    .entry_mark_us    (entry_mark_us),
    .entry_space_us   (entry_space_us)
  );

endmodule

>>> rtl/core/ooktc_checker.sv
// ----------------------------------------------------------------------------
// ooktc_checker
// Port-level checks on the capture unit's result items.
// ----------------------------------------------------------------------------
module ooktc_checker import ooktc_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 train_ready,
  input logic [COUNT_W-1:0]   ready_pair_count,
  input logic                 entry_valid,
  input logic [DUR_OUT_W-1:0] entry_mark_us,
  input logic [DUR_OUT_W-1:0] entry_space_us
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(train_ready) &&
      $stable(ready_pair_count) && $stable(entry_valid) &&
      $stable(entry_mark_us) && $stable(entry_space_us)))
    else $error("result item changed while stalled");

  a_entry_needs_train: assert property (@(posedge clk) disable iff (rst)
    (out_valid && entry_valid) |-> (train_ready && ready_pair_count != '0))
    else $error("entry valid without a ready train");

  a_idle_count_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !train_ready) |-> (ready_pair_count == '0))
    else $error("pair count shown without a ready train");

  a_invalid_entry_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !entry_valid) |-> (entry_mark_us == '0 && entry_space_us == '0))
    else $error("entry data on an invalid read");

endmodule

bind ook_pulse_train_capture_unit ooktc_checker u_ooktc_checker (.*);

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the OOK pulse train capture unit. A short table of
// hand-checked items walks edges, reads, releases, wrap and threshold corners.
// Random mark/space trains with noise then run under several timeout settings,
// and one long clean train. Fixed table rows are compared with their given
// values, all other results with an in-bench model of the capture buffers.
// ----------------------------------------------------------------------------
module tb_top;
  import ooktc_pkg::*;

  localparam int DEPTH = PAIR_DEPTH_DEF;
  localparam logic [DUR_OUT_W-1:0] DUR_MAX = DUR_OUT_W'((1 << DURATION_BITS_DEF) - 1);
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int NUM_PHASES = 6;
  localparam int PHASE_ITEMS = 265;

  typedef struct packed {
    logic                 train_ready;
    logic [COUNT_W-1:0]   count;
    logic                 valid;
    logic [DUR_OUT_W-1:0] mark;
    logic [DUR_OUT_W-1:0] space;
  } cap_status_t;

  typedef struct {
    logic [CMD_W-1:0]  c;
    logic [TIME_W-1:0] t;
    logic              hi;
    logic [IDX_W-1:0]  idx;
    bit                fixed;
    cap_status_t       want;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [TIMEOUT_W-1:0] cfg_wr_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CMD_W-1:0]     cmd = CMD_EDGE;
  logic [TIME_W-1:0]    edge_time_us = '0;
  logic                 line_high = 1'b0;
  logic [IDX_W-1:0]     entry_index = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 train_ready;
  logic [COUNT_W-1:0]   ready_pair_count;
  logic                 entry_valid;
  logic [DUR_OUT_W-1:0] entry_mark_us;
  logic [DUR_OUT_W-1:0] entry_space_us;

  // capture model state
  logic [TIMEOUT_W-1:0] cap_timeout = TIMEOUT_RESET;
  logic [TIME_W-1:0]    last_ts = '0;
  logic                 mark_open = 1'b0;
  logic                 act_buf = 1'b0;
  logic                 train_wait = 1'b0;
  logic [COUNT_W-1:0]   pair_cnt [2] = '{default: '0};
  logic                 buf_rdy [2] = '{default: 1'b0};
  logic [DUR_OUT_W-1:0] mark_mem [2*DEPTH];
  logic [DUR_OUT_W-1:0] space_mem [2*DEPTH];

  cap_status_t status_fifo [$];
  dir_row_t    dir_rows [$];
  int          err_cnt = 0;
  int          n_items = 0;
  int          n_settings = 0;
  int          trains_closed = 0;
  int          valid_reads = 0;
  bit          in_burst = 1'b0;
  bit          out_burst = 1'b0;

  ook_pulse_train_capture_unit u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .cmd              (cmd),
    .edge_time_us     (edge_time_us),
    .line_high        (line_high),
    .entry_index      (entry_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .train_ready      (train_ready),
    .ready_pair_count (ready_pair_count),
    .entry_valid      (entry_valid),
    .entry_mark_us    (entry_mark_us),
    .entry_space_us   (entry_space_us)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #(20_000_000);
    $display("Some tests failed");
    $finish;
  end

  function automatic int draw_wait(inout bit burst);
    if ($urandom_range(0, 63) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic int ready_count();
    return (train_wait && buf_rdy[~act_buf]) ? int'(pair_cnt[~act_buf]) : 0;
  endfunction

  function automatic dir_row_t row(logic [CMD_W-1:0] c, logic [TIME_W-1:0] t, logic hi,
                                   logic [IDX_W-1:0] idx, int fixed, int rdy,
                                   int cnt, int vld, int mk, int sp);
    dir_row_t r;
    r.c = c;
    r.t = t;
    r.hi = hi;
    r.idx = idx;
    r.fixed = (fixed != 0);
    r.want = {1'(rdy), COUNT_W'(cnt), 1'(vld), DUR_OUT_W'(mk), DUR_OUT_W'(sp)};
    return r;
  endfunction

  // one item through the capture buffers; returns the status after the update
  task automatic step_capture(input logic [CMD_W-1:0] c, input logic [TIME_W-1:0] t,
                              input logic hi, input logic [IDX_W-1:0] idx,
                              output cap_status_t s);
    logic [TIME_W-1:0]    dur;
    logic [DUR_OUT_W-1:0] dclip;
    logic [COUNT_W-1:0]   n;
    logic                 a;
    logic                 rb;
    s = '0;
    if (c == CMD_EDGE) begin
      dur = t - last_ts;
      dclip = (dur > DUR_MAX) ? DUR_MAX : dur[DUR_OUT_W-1:0];
      a = act_buf;
      n = pair_cnt[a];
      last_ts = t;
      if (hi) begin
        if (dur >= cap_timeout) begin
          if (n > 1 && !buf_rdy[a]) begin
            buf_rdy[a] = 1'b1;
            train_wait = 1'b1;
            a = ~a;
            act_buf = a;
            pair_cnt[a] = '0;
            buf_rdy[a] = 1'b0;
            trains_closed++;
          end else begin
            pair_cnt[a] = '0;
          end
        end else if (n > 0 && n <= DEPTH) begin
          space_mem[int'(a) * DEPTH + int'(n) - 1] = dclip;
        end
        mark_open = 1'b1;
      end else if (mark_open) begin
        mark_open = 1'b0;
        if (dur >= cap_timeout) begin
          pair_cnt[a] = '0;
        end else if (n < DEPTH) begin
          mark_mem[int'(a) * DEPTH + int'(n)] = dclip;
          space_mem[int'(a) * DEPTH + int'(n)] = '0;
          pair_cnt[a] = n + COUNT_W'(1);
        end
      end
    end else if (c == CMD_RELEASE) begin
      rb = ~act_buf;
      if (train_wait && buf_rdy[rb]) begin
        buf_rdy[rb] = 1'b0;
        train_wait = 1'b0;
      end
    end
    rb = ~act_buf;
    s.train_ready = train_wait && buf_rdy[rb];
    if (s.train_ready) s.count = pair_cnt[rb];
    if (c == CMD_READ && s.train_ready && idx < s.count) begin
      s.valid = 1'b1;
      s.mark = mark_mem[int'(rb) * DEPTH + int'(idx)];
      if (idx + 1 < s.count) s.space = space_mem[int'(rb) * DEPTH + int'(idx)];
      valid_reads++;
    end
  endtask

  task automatic send_item(input logic [CMD_W-1:0] c, input logic [TIME_W-1:0] t,
                           input logic hi, input logic [IDX_W-1:0] idx,
                           input bit fixed, input cap_status_t want);
    int          gap;
    cap_status_t pred;
    gap = draw_wait(in_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    edge_time_us <= t;
    line_high <= hi;
    entry_index <= idx;
    do @(posedge clk); while (in_ready !== 1'b1);
    step_capture(c, t, hi, idx, pred);
    status_fifo.push_back(fixed ? want : pred);
    n_items++;
  endtask

  task automatic send_edge(input logic hi, input logic [TIME_W-1:0] dur);
    send_item(CMD_EDGE, last_ts + dur, hi, IDX_W'($urandom_range(0, 1023)), 1'b0, '0);
  endtask

  task automatic set_timeout(input logic [TIMEOUT_W-1:0] v);
    in_valid <= 1'b0;
    while (status_fifo.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cap_timeout = v;
    n_settings++;
  endtask

  function automatic logic [TIME_W-1:0] short_dur();
    if (cap_timeout == 0) return $urandom_range(0, 1000);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return cap_timeout - 1;
      default: return $urandom_range(0, cap_timeout - 1);
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] long_dur();
    case ($urandom_range(0, 3))
      0: return cap_timeout;
      1: return $urandom();
      default: return cap_timeout + $urandom_range(0, 5000);
    endcase
  endfunction

  task automatic serve_reads();
    int               c;
    int               k;
    logic [IDX_W-1:0] idx;
    k = $urandom_range(0, 4);
    repeat (k) begin
      c = ready_count();
      case ($urandom_range(0, 5))
        0: idx = IDX_W'($urandom_range(0, 1023));
        1: idx = IDX_W'(c);
        default: idx = (c > 0) ? IDX_W'($urandom_range(0, c - 1))
                               : IDX_W'($urandom_range(0, 1023));
      endcase
      send_item(CMD_READ, $urandom(), 1'($urandom_range(0, 1)), idx, 1'b0, '0);
    end
    if ($urandom_range(0, 1))
      send_item(CMD_RELEASE, $urandom(), 1'($urandom_range(0, 1)),
                IDX_W'($urandom_range(0, 1023)), 1'b0, '0);
    if ($urandom_range(0, 7) == 0)
      send_item(CMD_W'($urandom_range(0, 3)), $urandom(), 1'($urandom_range(0, 1)),
                IDX_W'($urandom_range(0, 1023)), 1'b0, '0);
  endtask

  // a train is marks and short spaces, closed by a long space
  task automatic run_train(input int pairs, input bit clean);
    if (!mark_open) send_edge(1'b1, long_dur());
    for (int i = 0; i < pairs; i++) begin
      if (!clean && $urandom_range(0, 5) == 0) serve_reads();
      if (!clean && $urandom_range(0, 24) == 0) send_edge(1'b0, long_dur());
      else send_edge(1'b0, short_dur());
      if (!clean && $urandom_range(0, 30) == 0) send_edge(1'b0, short_dur());
      send_edge(1'b1, (i == pairs - 1) ? long_dur() : short_dur());
    end
  endtask

  task automatic note_mismatch(input string what, input cap_status_t w, input cap_status_t g);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("MISMATCH %s: want rdy=%0d cnt=%0d vld=%0d mark=%0d space=%0d",
               what, w.train_ready, w.count, w.valid, w.mark, w.space);
      $display("  got rdy=%0d cnt=%0d vld=%0d mark=%0d space=%0d",
               g.train_ready, g.count, g.valid, g.mark, g.space);
    end
  endtask

  // result side
  initial begin
    cap_status_t got;
    int          stall;
    while (rst) @(posedge clk);
    forever begin
      stall = draw_wait(out_burst);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      got = {train_ready, ready_pair_count, entry_valid, entry_mark_us, entry_space_us};
      if (status_fifo.size() == 0) note_mismatch("unexpected item", '0, got);
      else if (got !== status_fifo[0]) note_mismatch("field", status_fifo.pop_front(), got);
      else void'(status_fifo.pop_front());
    end
  end

  // stimulus
  initial begin
    int stop;
    int len;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    dir_rows.push_back(row(CMD_READ,    32'd0, 1'b0, 10'd0, 1, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_RELEASE, 32'd0, 1'b0, 10'd0, 1, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_UNUSED,  32'hFFFF_FFFF, 1'b1, 10'h3FF, 1, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_EDGE,    32'd5,     1'b0, 10'd0, 1, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_EDGE,    32'd100,   1'b1, 10'd0, 1, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_EDGE,    32'd300,   1'b0, 10'd0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_EDGE,    32'd400,   1'b1, 10'd0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_EDGE,    32'd1400,  1'b0, 10'd0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_EDGE,    32'd11399, 1'b1, 10'd0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_EDGE,    32'd21398, 1'b0, 10'd0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_EDGE,    32'd31398, 1'b1, 10'd0, 1, 1, 3, 0, 0, 0));
    dir_rows.push_back(row(CMD_READ,    32'd0, 1'b0, 10'd0, 1, 1, 3, 1, 200, 100));
    dir_rows.push_back(row(CMD_READ,    32'd0, 1'b0, 10'd1, 1, 1, 3, 1, 1000, 9999));
    dir_rows.push_back(row(CMD_READ,    32'd0, 1'b0, 10'd2, 1, 1, 3, 1, 9999, 0));
    dir_rows.push_back(row(CMD_READ,    32'd0, 1'b0, 10'd3, 1, 1, 3, 0, 0, 0));
    dir_rows.push_back(row(CMD_READ,    32'd0, 1'b0, 10'd1023, 1, 1, 3, 0, 0, 0));
    dir_rows.push_back(row(CMD_EDGE,    32'd41398, 1'b0, 10'd0, 1, 1, 3, 0, 0, 0));
    dir_rows.push_back(row(CMD_EDGE,    32'd41448, 1'b1, 10'd0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_EDGE,    32'd41449, 1'b0, 10'd0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_EDGE,    32'd61449, 1'b1, 10'd0, 1, 1, 3, 0, 0, 0));
    dir_rows.push_back(row(CMD_RELEASE, 32'd0, 1'b0, 10'd0, 1, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_EDGE,    32'hFFFF_FF00, 1'b0, 10'd0, 1, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_EDGE,    32'hFFFF_FFF0, 1'b1, 10'd0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_EDGE,    32'h10, 1'b0, 10'd0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_EDGE,    32'h30, 1'b1, 10'd0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_EDGE,    32'h40, 1'b0, 10'd0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_EDGE,    32'h40 + 32'd10000, 1'b1, 10'd0, 1, 1, 2, 0, 0, 0));
    dir_rows.push_back(row(CMD_READ,    32'd0, 1'b0, 10'd0, 1, 1, 2, 1, 32, 32));
    dir_rows.push_back(row(CMD_READ,    32'd0, 1'b0, 10'd1, 1, 1, 2, 1, 16, 0));

    foreach (dir_rows[i])
      send_item(dir_rows[i].c, dir_rows[i].t, dir_rows[i].hi, dir_rows[i].idx,
                dir_rows[i].fixed, dir_rows[i].want);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: set_timeout(20'd1);
        1: set_timeout(20'd0);
        2: set_timeout(20'hFFFFF);
        3: set_timeout(TIMEOUT_W'($urandom_range(20, 3000)));
        4: set_timeout(TIMEOUT_W'($urandom_range(1, 20'hFFFFF)));
        default: set_timeout(TIMEOUT_W'($urandom_range(2, 400)));
      endcase
      stop = n_items + PHASE_ITEMS;
      while (n_items < stop) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        run_train(len, 1'b0);
        serve_reads();
      end
    end

    // long clean train, then read its first entry and the top of the index range
    set_timeout(TIMEOUT_RESET);
    send_item(CMD_RELEASE, '0, 1'b0, '0, 1'b0, '0);
    run_train($urandom_range(13, 40), 1'b1);
    send_item(CMD_READ, $urandom(), 1'b0, 10'd0, 1'b0, '0);
    send_item(CMD_READ, $urandom(), 1'b1, 10'd1022, 1'b0, '0);
    send_item(CMD_READ, $urandom(), 1'b0, 10'd1023, 1'b0, '0);
    send_item(CMD_READ, $urandom(), 1'b1, IDX_W'($urandom_range(0, 1023)), 1'b0, '0);
    send_item(CMD_RELEASE, $urandom(), 1'b0, '0, 1'b0, '0);
    repeat (6) begin
      run_train($urandom_range(0, 12), 1'b0);
      serve_reads();
    end

    in_valid <= 1'b0;
    for (int w = 0; w < 5000 && status_fifo.size() != 0; w++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (status_fifo.size() != 0) begin
      $display("%0d results never arrived", status_fifo.size());
      err_cnt += status_fifo.size();
    end
    $display("Run covered %0d items over %0d timeout settings, %0d trains closed",
             n_items, n_settings, trains_closed);
    $display("%0d in-range entry reads, %0d result errors", valid_reads, err_cnt);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
